>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property check, sampled on the rising clock, off while reset is high.
`define TPE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Condition that must never be seen on a clock edge outside reset.
`define TPE_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define TPE_ASSERT(lbl, clk, rst, prop)
`define TPE_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> sv/tpe_pkg.sv
package tpe_pkg;

   // Widths fixed by the field formats (sizes go up to 15, cells up to 64).
   localparam int SIZE_W      = 5;    // effective size 1..15
   localparam int NUM_W       = 10;   // size_x*size_y
   localparam int ADDR_W      = 14;   // flat coefficient read address
   localparam int ACC_W       = 40;   // Q20.20 accumulator
   localparam int COORD_W     = 32;   // Q16.16 coordinate
   localparam int DIFF_W      = 33;   // point minus center
   localparam int MAG_W       = 41;   // multiplicand magnitude
   localparam int PROD_W      = 57;   // partial product / rounded sum
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [2:0] {
      CSR_SIZE_X   = 3'd0,
      CSR_SIZE_Y   = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_INV_H    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [3:0]         size_x;
      logic [3:0]         size_y;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [31:0]        inv_h;
   } cfg_type;

   // One queued transaction, already classified by the front end.
   typedef struct packed {
      logic                     is_eval;
      logic                     cell_err;
      logic [ADDR_W-1:0]        base;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [11:0]              coef_addr;
      logic signed [31:0]       coef_value;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_NX,
      PH_NY,
      PH_ROW,
      PH_COL
   } phase_type;

   // Size register clamped to 1..max_size.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [3:0] raw,
                                                  input logic [SIZE_W-1:0] max_size);
      logic [SIZE_W-1:0] v;
      v = {1'b0, raw};
      if (v == '0) begin
         v = SIZE_W'(1);
      end else if (v > max_size) begin
         v = max_size;
      end
      return v;
   endfunction

endpackage

>>> sv/tpe_if.sv
interface tpe_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [11:0]        coef_addr;
   logic signed [31:0] coef_value;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic [5:0]         cell_index;

   modport source (output valid, func, coef_addr, coef_value, point_x, point_y,
                   cell_index, input ready);
   modport sink (input valid, func, coef_addr, coef_value, point_x, point_y,
                 cell_index, output ready);
endinterface

interface tpe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [39:0] poly_value;
   logic               cell_error;

   modport source (output valid, poly_value, cell_error, input ready);
   modport sink (input valid, poly_value, cell_error, output ready);
endinterface

>>> sv/tensor_poly_eval.sv
// Tensor-product polynomial evaluator. Each request transaction either loads one
// Q12.20 coefficient into the store (func 0, coef_addr = cell*size_x*size_y +
// row*size_x + column; addresses beyond the store are dropped) or evaluates the
// polynomial of cell_index at (point_x, point_y) (func 1). The point is normalized
// as (p - center) * inv_h in Q16.16, then one Horner pass in x runs per row and a
// final Horner pass in y runs over the row values; every product is rounded half
// away from zero and saturated, and the Q20.20 result is saturated to 40 bits.
// A cell_index not below size_x*size_y returns cell_error with a zero value. Sizes
// of 0 act as 1 and sizes above MAX_SIZE act as MAX_SIZE. The coefficient store has
// no reset and no clearing pass: load every coefficient of a cell before
// evaluating it. Registers are to be written through the csr_ port only while no
// transaction is in flight; the block itself does not enforce this. The front end
// classifies each request and parks it in a 4-entry queue, so requests keep
// flowing, until the queue is full, while the back end is busy or a result waits
// in the output register. A load is written to the store when popped. An evaluate
// runs on the single shared multiply-add unit: each Horner step takes a multiply
// state and a round/saturate/accumulate state, and each row adds a store fetch
// and load. A bad cell goes straight to the done state.
module tensor_poly_eval #(
   parameter int MAX_SIZE    = 8,
   parameter int STORE_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   tpe_req_if.sink     req_ch,
   tpe_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   tpe_pkg::cfg_type   cfg_ff, cfg_in;
   tpe_pkg::entry_type push_entry, head_entry;
   logic               q_push, q_pop, q_full, q_empty;

   // register file; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tpe_pkg::CSR_SIZE_X:   cfg_in.size_x   = csr_wdata[3:0];
            tpe_pkg::CSR_SIZE_Y:   cfg_in.size_y   = csr_wdata[3:0];
            tpe_pkg::CSR_CENTER_X: cfg_in.center_x = csr_wdata;
            tpe_pkg::CSR_CENTER_Y: cfg_in.center_y = csr_wdata;
            tpe_pkg::CSR_INV_H:    cfg_in.inv_h    = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x   <= 4'd3;
         cfg_ff.size_y   <= 4'd3;
         cfg_ff.center_x <= '0;
         cfg_ff.center_y <= '0;
         cfg_ff.inv_h    <= 32'd65536;   // 1.0 in Q16.16
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: accept, compute differences, cell check and base address
   tpe_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .req     (req_ch),
      .cfg     (cfg_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   // decoupling queue, loads and evaluates stay in order
   tpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (push_entry),
      .full     (q_full),
      .pop      (q_pop),
      .rd_entry (head_entry),
      .empty    (q_empty)
   );

   // back end: coefficient store, Horner sequencer, output register
   tpe_back #(
      .MAX_SIZE    (MAX_SIZE),
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_entry (head_entry),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

>>> sv/tpe_front.sv
module tpe_front #(
   parameter int MAX_SIZE = 8
) (
   tpe_req_if.sink              req,
   input  tpe_pkg::cfg_type     cfg,
   input  logic                 q_full,
   output logic                 q_push,
   output tpe_pkg::entry_type   q_entry
);

   logic [tpe_pkg::SIZE_W-1:0] sx;
   logic [tpe_pkg::SIZE_W-1:0] sy;
   logic [tpe_pkg::NUM_W-1:0]  n;
   logic [15:0]                base_full;

   assign sx = tpe_pkg::eff_size(cfg.size_x, tpe_pkg::SIZE_W'(MAX_SIZE));
   assign sy = tpe_pkg::eff_size(cfg.size_y, tpe_pkg::SIZE_W'(MAX_SIZE));
   assign n  = tpe_pkg::NUM_W'(sx) * tpe_pkg::NUM_W'(sy);

   // cell_index < 64, so base fits the read address when the cell is good
   assign base_full = 16'(req.cell_index) * 16'(n);

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_entry.is_eval    = req.func;
      q_entry.cell_err   = tpe_pkg::NUM_W'(req.cell_index) >= n;
      q_entry.base       = base_full[tpe_pkg::ADDR_W-1:0];
      q_entry.dx         = {req.point_x[31], req.point_x} - {cfg.center_x[31], cfg.center_x};
      q_entry.dy         = {req.point_y[31], req.point_y} - {cfg.center_y[31], cfg.center_y};
      q_entry.coef_addr  = req.coef_addr;
      q_entry.coef_value = req.coef_value;
   end

endmodule

>>> sv/tpe_queue.sv
`include "assert_macros.svh"

module tpe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpe_pkg::entry_type  wr_entry,
   output logic                full,
   input  logic                pop,
   output tpe_pkg::entry_type  rd_entry,
   output logic                empty
);

   tpe_pkg::entry_type             entries_ff [tpe_pkg::QUEUE_DEPTH];
   logic [tpe_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tpe_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tpe_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign full     = count_ff == tpe_pkg::QCNT_W'(tpe_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign rd_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   `TPE_ASSERT(a_count_tracks_push, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
   `TPE_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && empty)

endmodule

>>> sv/tpe_back.sv
`include "assert_macros.svh"

module tpe_back #(
   parameter int MAX_SIZE    = 8,
   parameter int STORE_DEPTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  tpe_pkg::cfg_type    cfg,
   input  tpe_pkg::entry_type  q_entry,
   input  logic                q_empty,
   output logic                q_pop,
   tpe_rsp_if.source           rsp
);

   localparam int SW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = ((SW > tpe_pkg::ADDR_W) ? SW : tpe_pkg::ADDR_W) + 1;
   localparam int RW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int AW = tpe_pkg::ADDR_W;
   localparam int PW = tpe_pkg::PROD_W;
   localparam int MW = tpe_pkg::MAG_W;
   localparam int XW = tpe_pkg::ACC_W;
   localparam int TW = tpe_pkg::COORD_W;
   localparam logic [PW-1:0] LIM_NORM = PW'(64'h8000_0000);
   localparam logic [PW-1:0] LIM_ACC  = PW'(64'h80_0000_0000);
   localparam logic [XW-1:0] ACC_MAX  = {1'b0, {(XW-1){1'b1}}};
   localparam logic [XW-1:0] ACC_MIN  = {1'b1, {(XW-1){1'b0}}};

   // coefficient store and row values
   logic [31:0]   coef_mem [STORE_DEPTH];
   logic [XW-1:0] rows_ff  [MAX_SIZE];

   tpe_pkg::state_type state_ff, state_in;
   tpe_pkg::phase_type phase_ff, phase_in;

   logic [XW-1:0]                acc_ff, acc_in;
   logic [TW-1:0]                tx_ff, tx_in, ty_ff, ty_in;
   logic [tpe_pkg::DIFF_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic                         err_ff, err_in;
   logic [AW-1:0]                row_base_ff, row_base_in, rd_addr_ff, rd_addr_in;
   logic [RW-1:0]                row_ff, row_in, col_ff, col_in;
   logic [PW-1:0]                prod_hi_ff, prod_lo_ff;
   logic                         neg_ff;
   logic [31:0]                  rd_data_ff;
   logic                         rd_oor_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]                rsp_value_ff, rsp_value_in;
   logic                         rsp_err_ff, rsp_err_in;

   logic [tpe_pkg::SIZE_W-1:0]   sx, sy;
   logic [RW-1:0]                sx_m1, sy_m1;
   logic [AW-1:0]                sx_a, next_base, next_start;
   logic                         row_last, row_done, out_free;
   tpe_pkg::state_type           row_exit;

   // memory port
   logic [CW-1:0]                wr_wide, rd_wide;
   logic                         wr_in_range, rd_in_range, mem_we;
   logic [SW-1:0]                wr_idx, rd_idx;

   // shared multiply-add
   logic [MW-1:0]                op_a, a_mag;
   logic [TW-1:0]                op_t, t_mag;
   logic                         t_neg, mul_en, is_norm;
   logic [PW-1:0]                prod_hi_in, prod_lo_in, lo_round, mag_r, lim;
   logic [MW-1:0]                cap_mag;
   logic [MW:0]                  pmag, prod_s, coef_term, sum;
   logic [XW-1:0]                sum_sat, coef_ext, rows_wdata;
   logic [31:0]                  coef_now;
   logic                         rows_we;

   assign sx       = tpe_pkg::eff_size(cfg.size_x, tpe_pkg::SIZE_W'(MAX_SIZE));
   assign sy       = tpe_pkg::eff_size(cfg.size_y, tpe_pkg::SIZE_W'(MAX_SIZE));
   assign sx_m1    = RW'(sx - 1'b1);
   assign sy_m1    = RW'(sy - 1'b1);
   assign sx_a     = AW'(sx);
   assign next_base  = row_base_ff + sx_a;
   assign next_start = next_base + sx_a - 1'b1;
   assign row_last = row_ff == sy_m1;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign row_done = ((state_ff == tpe_pkg::ST_LOAD) && (sx_m1 == '0)) ||
                     ((state_ff == tpe_pkg::ST_ADD) && (phase_ff == tpe_pkg::PH_ROW) &&
                      (col_ff == RW'(1)));
   assign row_exit = !row_last ? tpe_pkg::ST_FETCH :
                     (row_ff == '0) ? tpe_pkg::ST_DONE : tpe_pkg::ST_MUL;

   // ---- coefficient store: one write port, one registered read port ----
   assign wr_wide     = CW'(q_entry.coef_addr);
   assign wr_in_range = wr_wide < CW'(STORE_DEPTH);
   assign wr_idx      = wr_wide[SW-1:0];
   assign rd_wide     = CW'(rd_addr_ff);
   assign rd_in_range = rd_wide < CW'(STORE_DEPTH);
   assign rd_idx      = rd_in_range ? rd_wide[SW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         coef_mem[wr_idx] <= q_entry.coef_value;
      end
      rd_data_ff <= coef_mem[rd_idx];
      rd_oor_ff  <= !rd_in_range;
   end

   assign coef_now = rd_oor_ff ? '0 : rd_data_ff;
   assign coef_ext = {{(XW-32){coef_now[31]}}, coef_now};

   // ---- multiply stage: magnitudes and two 16-bit slices of the coordinate ----
   always_comb begin
      op_a  = {{(MW-XW){acc_ff[XW-1]}}, acc_ff};
      op_t  = tx_ff;
      t_neg = 1'b0;
      unique case (phase_ff)
         tpe_pkg::PH_NX: begin
            op_a = {{(MW-tpe_pkg::DIFF_W){dx_ff[tpe_pkg::DIFF_W-1]}}, dx_ff};
            op_t = cfg.inv_h;
         end
         tpe_pkg::PH_NY: begin
            op_a = {{(MW-tpe_pkg::DIFF_W){dy_ff[tpe_pkg::DIFF_W-1]}}, dy_ff};
            op_t = cfg.inv_h;
         end
         tpe_pkg::PH_ROW: begin
            op_t  = tx_ff;
            t_neg = tx_ff[TW-1];
         end
         tpe_pkg::PH_COL: begin
            op_t  = ty_ff;
            t_neg = ty_ff[TW-1];
         end
         default: begin
            op_t = tx_ff;
         end
      endcase
      a_mag      = op_a[MW-1] ? (~op_a + 1'b1) : op_a;
      t_mag      = t_neg ? (~op_t + 1'b1) : op_t;
      prod_hi_in = PW'(a_mag) * PW'(t_mag[31:16]);
      prod_lo_in = PW'(a_mag) * PW'(t_mag[15:0]);
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
         neg_ff     <= op_a[MW-1] ^ t_neg;
      end
   end

   // ---- add stage: round half away from zero, clamp, sign, accumulate ----
   assign is_norm  = (phase_ff == tpe_pkg::PH_NX) || (phase_ff == tpe_pkg::PH_NY);
   assign lo_round = (prod_lo_ff + PW'(32768)) >> 16;
   assign mag_r    = prod_hi_ff + lo_round;
   assign lim      = is_norm ? LIM_NORM : LIM_ACC;

   always_comb begin
      if (mag_r >= lim) begin
         cap_mag = neg_ff ? MW'(lim) : MW'(lim - 1'b1);
      end else begin
         cap_mag = MW'(mag_r);
      end
      pmag   = {1'b0, cap_mag};
      prod_s = neg_ff ? (~pmag + 1'b1) : pmag;
      unique case (phase_ff)
         tpe_pkg::PH_ROW: coef_term = {{(MW+1-XW){coef_ext[XW-1]}}, coef_ext};
         tpe_pkg::PH_COL: coef_term = {{(MW+1-XW){rows_ff[row_ff - 1'b1][XW-1]}},
                                       rows_ff[row_ff - 1'b1]};
         default:         coef_term = '0;
      endcase
      sum = prod_s + coef_term;
      if ((sum[MW:XW-1] == '0) || (sum[MW:XW-1] == '1)) begin
         sum_sat = sum[XW-1:0];
      end else if (sum[MW]) begin
         sum_sat = ACC_MIN;
      end else begin
         sum_sat = ACC_MAX;
      end
   end

   // ---- sequencer: next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpe_pkg::ST_IDLE: begin
            if (!q_empty && q_entry.is_eval) begin
               state_in = q_entry.cell_err ? tpe_pkg::ST_DONE : tpe_pkg::ST_MUL;
            end
         end
         tpe_pkg::ST_FETCH: state_in = tpe_pkg::ST_LOAD;
         tpe_pkg::ST_LOAD: state_in = row_done ? row_exit : tpe_pkg::ST_MUL;
         tpe_pkg::ST_MUL: state_in = tpe_pkg::ST_ADD;
         tpe_pkg::ST_ADD: begin
            unique case (phase_ff)
               tpe_pkg::PH_NX:  state_in = tpe_pkg::ST_MUL;
               tpe_pkg::PH_NY:  state_in = tpe_pkg::ST_FETCH;
               tpe_pkg::PH_ROW: state_in = row_done ? row_exit : tpe_pkg::ST_MUL;
               tpe_pkg::PH_COL: state_in = (row_ff == RW'(1)) ? tpe_pkg::ST_DONE
                                                              : tpe_pkg::ST_MUL;
               default:         state_in = tpe_pkg::ST_IDLE;
            endcase
         end
         tpe_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tpe_pkg::ST_IDLE;
            end
         end
         default: state_in = tpe_pkg::ST_IDLE;
      endcase
   end

   // ---- sequencer: datapath controls ----
   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      err_in       = err_ff;
      row_base_in  = row_base_ff;
      rd_addr_in   = rd_addr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mul_en       = 1'b0;
      rows_we      = 1'b0;
      rows_wdata   = (state_ff == tpe_pkg::ST_LOAD) ? coef_ext : sum_sat;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         tpe_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_entry.is_eval) begin
                  dx_in       = q_entry.dx;
                  dy_in       = q_entry.dy;
                  err_in      = q_entry.cell_err;
                  row_base_in = q_entry.base;
                  acc_in      = '0;
                  row_in      = '0;
                  phase_in    = tpe_pkg::PH_NX;
               end else begin
                  mem_we = wr_in_range;
               end
            end
         end
         tpe_pkg::ST_FETCH: begin
         end
         tpe_pkg::ST_LOAD: begin
            acc_in     = coef_ext;
            col_in     = sx_m1;
            rd_addr_in = rd_addr_ff - 1'b1;
         end
         tpe_pkg::ST_MUL: begin
            mul_en = 1'b1;
         end
         tpe_pkg::ST_ADD: begin
            unique case (phase_ff)
               tpe_pkg::PH_NX: begin
                  tx_in    = prod_s[TW-1:0];
                  phase_in = tpe_pkg::PH_NY;
               end
               tpe_pkg::PH_NY: begin
                  ty_in      = prod_s[TW-1:0];
                  phase_in   = tpe_pkg::PH_ROW;
                  rd_addr_in = row_base_ff + sx_a - 1'b1;
               end
               tpe_pkg::PH_ROW: begin
                  acc_in     = sum_sat;
                  col_in     = col_ff - 1'b1;
                  rd_addr_in = rd_addr_ff - 1'b1;
               end
               tpe_pkg::PH_COL: begin
                  acc_in = sum_sat;
                  row_in = row_ff - 1'b1;
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
         end
         tpe_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff;
               rsp_err_in   = err_ff;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
      // end of an x pass: keep the row value, move to the next row or to the y pass
      if (row_done) begin
         rows_we = 1'b1;
         if (row_last) begin
            phase_in = tpe_pkg::PH_COL;
         end else begin
            row_in      = row_ff + 1'b1;
            row_base_in = next_base;
            rd_addr_in  = next_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpe_pkg::ST_IDLE;
         phase_ff     <= tpe_pkg::PH_NX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      err_ff       <= err_in;
      row_base_ff  <= row_base_in;
      rd_addr_ff   <= rd_addr_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
      if (rows_we) begin
         rows_ff[row_ff] <= rows_wdata;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.poly_value = rsp_value_ff;
   assign rsp.cell_error = rsp_err_ff;

   `TPE_ASSERT(a_add_follows_mul, clock, reset, (state_ff == tpe_pkg::ST_ADD) |-> ($past(state_ff) == tpe_pkg::ST_MUL))
   `TPE_ASSERT(a_load_follows_fetch, clock, reset, (state_ff == tpe_pkg::ST_LOAD) |-> ($past(state_ff) == tpe_pkg::ST_FETCH))
   `TPE_ASSERT(a_error_gives_zero, clock, reset, (rsp_valid_ff && rsp_err_ff) |-> (rsp_value_ff == '0))

endmodule
